### hdl/sorted_priority_queue_macros.svh
// ============================================================================
// Sorted priority queue assertion macros
// Concurrent assertion wrappers that are compiled out for synthesis.
// ============================================================================
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion that is switched off while reset is held.
`define SPQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sorted_priority_queue: assertion failed");

// Clocked assertion that is also checked while reset is held.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sorted_priority_queue: assertion failed");

`else

`define SPQ_ASSERT(lbl, clk, rstn, prop)

`define SPQ_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### hdl/spq_pkg.sv
// ============================================================================
// Sorted priority queue package
// Sizes, codes and data types shared by the queue's modules.
// ============================================================================
`timescale 1ns / 1ps

package spq_pkg;

    // Number of cells in the chain.
    localparam int CAPACITY = 16;
    // Count width, wide enough to hold CAPACITY itself.
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int VAL_W    = 32;
    localparam int PRI_W    = 16;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;

    // Request kinds.
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    // One stored entry.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [PRI_W-1:0] prio;
    } entry_t;

    // Operation broadcast to every cell.
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

    // One result word.
    typedef struct packed {
        logic        [STAT_W-1:0] status;
        logic signed [VAL_W-1:0]  head_value;
        logic signed [PRI_W-1:0]  head_priority;
        logic        [OCC_W-1:0]  occupancy;
    } result_t;

endpackage

### hdl/sorted_priority_queue.sv
// ============================================================================
// Sorted priority queue
// Priority queue built as a chain of cells kept in ascending priority order.
// ============================================================================
// The queue holds up to CAPACITY entries, sorted so that the smallest priority
// sits in the first cell; equal priorities leave in arrival order. Each request
// word yields exactly one result word. When a request is taken, every
// cell compares its priority with the incoming one at once and the whole chain
// shifts in that same clock edge, so one word per cycle is sustained while the
// result side keeps up. An output register and a skid stage stand between the
// chain and the result port, so a single stalled result does not stop input.
// No clearing pass is needed after reset; the occupancy count alone says which
// cells hold entries.
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Request words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] item_value, [47:32] item_priority
    input  logic [0:0]  s_tuser,   // [0] req_type
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] head_value, [47:32] head_priority,
                                   // [52:48] occupancy, [55:53] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic       s_fire;
    logic       req_type;
    logic       full;
    logic       empty;
    entry_t     new_entry;
    cell_ctrl_t ctrl;
    result_t    result;
    result_t    out_data;
    logic       skid_valid;

    entry_t cell_entry [CAPACITY];
    logic   cell_keep  [CAPACITY];
    logic   cell_occ   [CAPACITY];

    assign s_fire          = s_tvalid && s_tready;
    assign req_type        = s_tuser[0];
    assign new_entry.value = s_tdata[31:0];
    assign new_entry.prio  = s_tdata[47:32];
    assign full            = (count_reg == CNT_W'(CAPACITY));
    assign empty           = (count_reg == '0);

    // Operation broadcast to the chain.
    assign ctrl.enq = s_fire && (req_type == REQ_ENQ) && !full;
    assign ctrl.deq = s_fire && (req_type == REQ_DEQ) && !empty;

    // Chain of cells.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t left_e;
        logic   left_k;
        entry_t right_e;

        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            assign left_e = new_entry;
            assign left_k = 1'b1;
        end else begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_k = cell_keep[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_e = cell_entry[i];
        end else begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (cell_occ[i]),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_keep   (left_k),
            .right_entry (right_e),
            .keep        (cell_keep[i]),
            .entry       (cell_entry[i])
        );
    end

    // Occupancy count.
    always_comb begin
        count_next = count_reg;
        if (ctrl.enq) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.deq) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result word, formed from the chain as it stands at acceptance.
    always_comb begin
        result.status        = ST_OK;
        result.head_value    = cell_entry[0].value;
        result.head_priority = cell_entry[0].prio;
        result.occupancy     = OCC_W'(count_next);
        if (req_type == REQ_ENQ) begin
            if (full) begin
                result.status = ST_OVERFLOW;
            end else if (!cell_keep[0]) begin
                // The new entry becomes the head.
                result.head_value    = new_entry.value;
                result.head_priority = new_entry.prio;
            end
        end else if (empty) begin
            result.status        = ST_UNDERFLOW;
            result.head_value    = '0;
            result.head_priority = '0;
        end
    end

    // Output register and skid stage.
    spq_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data),
        .skid_valid (skid_valid)
    );

    assign m_tdata = {3'b000, out_data.occupancy, out_data.head_priority,
                      out_data.head_value};
    assign m_tuser = out_data.status;

    // Checks.
    `SPQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY))
    `SPQ_ASSERT(a_deq_count, aclk, aresetn, ctrl.deq |=> count_reg == $past(count_reg) - 1'b1)
    `SPQ_ASSERT(a_skid_order, aclk, aresetn, skid_valid |-> m_tvalid)
    `SPQ_ASSERT(a_sorted_head, aclk, aresetn, cell_occ[1] |-> $signed(cell_entry[0].prio) <= $signed(cell_entry[1].prio))
    `SPQ_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid && count_reg == '0)

endmodule

### hdl/spq_cell.sv
// ============================================================================
// Sorted priority queue cell
// Holds one entry and shifts it or takes a new one as the chain moves.
// ============================================================================
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  entry_t     new_entry,
    input  entry_t     left_entry,
    input  logic       left_keep,
    input  entry_t     right_entry,
    output logic       keep,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // A held entry stays put when its priority does not exceed the new one.
    assign keep = occupied && ($signed(entry_reg.prio) <= $signed(new_entry.prio));

    // On insert, the first cell that does not keep takes the new entry and the
    // rest move one place right; on removal every cell takes its right neighbour.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.enq && !keep) begin
            entry_next = left_keep ? new_entry : left_entry;
        end else if (ctrl.deq) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### hdl/spq_out_buf.sv
// ============================================================================
// Sorted priority queue output buffer
// Output register with one skid stage so input and output stall independently.
// ============================================================================
`timescale 1ns / 1ps

module spq_out_buf
    import spq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data,
    output logic    skid_valid
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    in_fire;
    logic    out_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_data_reg <= in_data;
            end else begin
                skid_data_reg <= in_data;
            end
        end else if (out_fire && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign skid_valid = skid_valid_reg;

endmodule
